### rtl/line_text_buffer_editor_macros.svh
// Assertion macros used by the checker file lte_checker.
`ifndef LINE_TEXT_BUFFER_EDITOR_MACROS_SVH
`define LINE_TEXT_BUFFER_EDITOR_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LTE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define LTE_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### rtl/lte_pkg.sv
// ----------------------------------------------------------------------------
// lte_pkg
// Types, constants and command/status bundles of the line text buffer editor.
// ----------------------------------------------------------------------------
package lte_pkg;

	localparam int LINES  = 64;
	localparam int COLS   = 128;
	localparam int ROW_W  = 6;
	localparam int COL_W  = 7;
	localparam int CNT_W  = 7;
	localparam int ADDR_W = ROW_W + COL_W;

	localparam logic [COL_W-1:0] MAX_LEN    = COL_W'(COLS - 1);
	localparam logic [CNT_W-1:0] LINE_LIMIT = CNT_W'(LINES);
	localparam logic [7:0]       SPACE      = 8'h20;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_DELETE = 3'd1;
	localparam logic [2:0] OP_SPLIT  = 3'd2;
	localparam logic [2:0] OP_MERGE  = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	typedef struct packed {
		logic [2:0]       req_type;
		logic [7:0]       ch;
		logic [ROW_W-1:0] cursor_row;
		logic [COL_W-1:0] cursor_col;
	} req_t;

	typedef struct packed {
		logic             status;
		logic [ROW_W-1:0] new_row;
		logic [COL_W-1:0] new_col;
		logic [CNT_W-1:0] line_count;
		logic [COL_W-1:0] line_length;
		logic [7:0]       char_out;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic init_step;
		logic load_req;
		logic look_row;
		logic look_aux;
		logic look_len;
		logic decide;
		logic cp_prime;
		logic cp_move;
		logic wr_ch;
		logic len_a;
		logic len_b;
		logic mp_prime;
		logic mp_move;
		logic mp_last;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic init_last;
		logic refuse;
		logic is_read;
		logic cp_zero;
		logic cp_one;
		logic do_ch;
		logic do_len_a;
		logic do_len_b;
		logic do_map;
		logic mp_at_end;
		logic mp_near_end;
	} stat_t;

	typedef enum logic [14:0] {
		S_INIT     = 15'b000000000000001,
		S_IDLE     = 15'b000000000000010,
		S_LOOK_ROW = 15'b000000000000100,
		S_LOOK_AUX = 15'b000000000001000,
		S_LOOK_LEN = 15'b000000000010000,
		S_DECIDE   = 15'b000000000100000,
		S_CP_PRIME = 15'b000000001000000,
		S_CP_MOVE  = 15'b000000010000000,
		S_WR_CH    = 15'b000000100000000,
		S_LEN_A    = 15'b000001000000000,
		S_LEN_B    = 15'b000010000000000,
		S_MP_PRIME = 15'b000100000000000,
		S_MP_MOVE  = 15'b001000000000000,
		S_MP_LAST  = 15'b010000000000000,
		S_DONE     = 15'b100000000000000
	} state_t;

endpackage

### rtl/line_text_buffer_editor.sv
// ----------------------------------------------------------------------------
// line_text_buffer_editor
// Line-array text buffer: insert, delete, split, merge and read at a cursor.
// ----------------------------------------------------------------------------
// Read and refused requests pass row lookup, slot lookup, length lookup and the
// decision before the done strobe. Edits add the byte copy, the byte and length
// writes, and for split/merge a line map walk.
// One request at a time; busy stays high until the strobe. The receiver cannot stall.
// Reset: the line map is set to identity and the lengths cleared in a pass over
// all 64 entries; busy is high during that pass.
module line_text_buffer_editor import lte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output res_t result
);

	cmd_t  cmd;
	stat_t stat;

	lte_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	lte_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.result (result)
	);

endmodule

### rtl/lte_ctrl.sv
// ----------------------------------------------------------------------------
// lte_ctrl
// Sequencer: clearing pass, lookup, copy loop, length and line map updates.
// ----------------------------------------------------------------------------
module lte_ctrl import lte_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	function automatic state_t after_len(input stat_t s);
		return s.do_map ? S_MP_PRIME : S_DONE;
	endfunction

	function automatic state_t after_copy(input stat_t s);
		state_t nxt;
		if (s.do_ch) begin
			nxt = S_WR_CH;
		end else if (s.do_len_a) begin
			nxt = S_LEN_A;
		end else begin
			nxt = after_len(s);
		end
		return nxt;
	endfunction

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_INIT: begin
				cmd.init_step = 1'b1;
				if (stat.init_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.load_req = 1'b1;
					state_d      = S_LOOK_ROW;
				end
			end
			S_LOOK_ROW: begin
				cmd.look_row = 1'b1;
				state_d      = S_LOOK_AUX;
			end
			S_LOOK_AUX: begin
				cmd.look_aux = 1'b1;
				state_d      = S_LOOK_LEN;
			end
			S_LOOK_LEN: begin
				cmd.look_len = 1'b1;
				state_d      = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = (stat.refuse || stat.is_read) ? S_DONE : S_CP_PRIME;
			end
			S_CP_PRIME: begin
				if (stat.cp_zero) begin
					state_d = after_copy(stat);
				end else begin
					cmd.cp_prime = 1'b1;
					state_d      = S_CP_MOVE;
				end
			end
			S_CP_MOVE: begin
				cmd.cp_move = 1'b1;
				if (stat.cp_one) state_d = after_copy(stat);
			end
			S_WR_CH: begin
				cmd.wr_ch = 1'b1;
				state_d   = S_LEN_A;
			end
			S_LEN_A: begin
				cmd.len_a = 1'b1;
				state_d   = stat.do_len_b ? S_LEN_B : after_len(stat);
			end
			S_LEN_B: begin
				cmd.len_b = 1'b1;
				state_d   = after_len(stat);
			end
			S_MP_PRIME: begin
				if (stat.mp_at_end) begin
					state_d = S_MP_LAST;
				end else begin
					cmd.mp_prime = 1'b1;
					state_d      = S_MP_MOVE;
				end
			end
			S_MP_MOVE: begin
				cmd.mp_move = 1'b1;
				if (stat.mp_near_end) state_d = S_MP_LAST;
			end
			S_MP_LAST: begin
				cmd.mp_last = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

### rtl/lte_dpath.sv
// ----------------------------------------------------------------------------
// lte_dpath
// Text store, per-slot lengths, row-to-slot map and the request datapath.
// ----------------------------------------------------------------------------
module lte_dpath import lte_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  req,
	input  cmd_t  cmd,
	output stat_t stat,
	output logic  done,
	output res_t  result
);

	// storage; rows map to physical slots, unused rows hold the free slots
	logic [7:0]       txt_mem [LINES*COLS];
	logic [COL_W-1:0] len_mem [LINES];
	logic [ROW_W-1:0] map_mem [LINES];

	logic [7:0]       txt_rd_q;
	logic [COL_W-1:0] len_rd_q;
	logic [ROW_W-1:0] map_rd_q;

	logic [ADDR_W-1:0] txt_ra, txt_wa;
	logic [7:0]        txt_wd;
	logic              txt_we;
	logic [ROW_W-1:0]  len_wa, map_ra, map_wa, map_wd;
	logic [COL_W-1:0]  len_wd;
	logic              len_we, map_we;

	req_t             req_q;
	logic [CNT_W-1:0] count_q;
	logic [ROW_W-1:0] init_idx_q;
	logic [ROW_W-1:0] phys_q, aux_q;
	logic [COL_W-1:0] len_q;

	logic [ADDR_W-1:0] src_q, dst_q;
	logic [COL_W-1:0]  n_q;
	logic              cp_dec_q, fill_q;
	logic              do_ch_q, do_a_q, do_b_q, do_map_q, read_hit_q;
	logic [ROW_W-1:0]  a_idx_q;
	logic [COL_W-1:0]  a_val_q, b_val_q;
	logic [ROW_W-1:0]  mp_w_q, mp_r_q, mp_end_q, mp_last_q;
	logic              mp_dec_q;

	res_t res_q;
	logic done_q;

	// plan of the request, valid while deciding
	logic             p_refuse, p_read_hit, p_dec, p_fill;
	logic             p_ch, p_a, p_b, p_map, p_mdec;
	logic [ROW_W-1:0] p_row, p_a_idx, p_mw, p_mr, p_mend, p_mlast;
	logic [COL_W-1:0] p_col, p_llen, p_a_val, p_b_val, p_n;
	logic [CNT_W-1:0] p_count;
	logic [ADDR_W-1:0] p_src, p_dst;
	logic [ROW_W-1:0] row, aux_idx;
	logic [COL_W-1:0] col, alen, sc, room, take, newlen;
	logic             bad;

	assign row     = req_q.cursor_row;
	assign col     = req_q.cursor_col;
	assign alen    = len_rd_q;
	assign bad     = ({1'b0, row} >= count_q);
	assign sc      = (col < len_q) ? col : len_q;
	assign room    = MAX_LEN - alen;
	assign take    = (len_q < room) ? len_q : room;
	assign newlen  = ((col > len_q) ? col : len_q) + 1'b1;
	assign aux_idx = (req_q.req_type == OP_MERGE) ? row - 1'b1 : count_q[ROW_W-1:0];

	always_comb begin
		p_refuse   = 1'b1;
		p_read_hit = 1'b0;
		p_row      = row;
		p_col      = col;
		p_llen     = bad ? '0 : len_q;
		p_count    = count_q;
		p_src      = {phys_q, col};
		p_dst      = {phys_q, col};
		p_n        = '0;
		p_dec      = 1'b0;
		p_fill     = 1'b0;
		p_ch       = 1'b0;
		p_a        = 1'b0;
		p_a_idx    = phys_q;
		p_a_val    = len_q;
		p_b        = 1'b0;
		p_b_val    = '0;
		p_map      = 1'b0;
		p_mw       = row;
		p_mr       = row;
		p_mend     = row;
		p_mdec     = 1'b0;
		p_mlast    = phys_q;
		if (!bad) begin
			case (req_q.req_type)
				OP_INSERT: begin
					if (col != MAX_LEN && len_q != MAX_LEN) begin
						p_refuse = 1'b0;
						p_dst    = {phys_q, len_q};
						if (col > len_q) begin
							p_fill = 1'b1;
							p_n    = col - len_q;
						end else begin
							p_dec = 1'b1;
							p_src = {phys_q, len_q - 1'b1};
							p_n   = len_q - col;
						end
						p_ch    = 1'b1;
						p_a     = 1'b1;
						p_a_val = newlen;
						p_col   = col + 1'b1;
						p_llen  = newlen;
					end
				end
				OP_DELETE: begin
					if (col != '0) begin
						p_refuse = 1'b0;
						p_col    = col - 1'b1;
						if (col <= len_q) begin
							p_src   = {phys_q, col};
							p_dst   = {phys_q, col - 1'b1};
							p_n     = len_q - col;
							p_a     = 1'b1;
							p_a_val = len_q - 1'b1;
							p_llen  = len_q - 1'b1;
						end
					end
				end
				OP_SPLIT: begin
					if (count_q != LINE_LIMIT) begin
						p_refuse = 1'b0;
						p_src    = {phys_q, sc};
						p_dst    = {aux_q, COL_W'(0)};
						p_n      = len_q - sc;
						p_a      = 1'b1;
						p_a_val  = sc;
						p_b      = 1'b1;
						p_b_val  = len_q - sc;
						p_map    = 1'b1;
						p_mw     = count_q[ROW_W-1:0];
						p_mr     = count_q[ROW_W-1:0] - 1'b1;
						p_mend   = row + 1'b1;
						p_mdec   = 1'b1;
						p_mlast  = aux_q;
						p_count  = count_q + 1'b1;
						p_row    = row + 1'b1;
						p_col    = '0;
						p_llen   = len_q - sc;
					end
				end
				OP_MERGE: begin
					if (row != '0) begin
						p_refuse = 1'b0;
						p_src    = {phys_q, COL_W'(0)};
						p_dst    = {aux_q, alen};
						p_n      = take;
						p_a      = 1'b1;
						p_a_idx  = aux_q;
						p_a_val  = alen + take;
						p_map    = 1'b1;
						p_mw     = row;
						p_mr     = row + 1'b1;
						p_mend   = count_q[ROW_W-1:0] - 1'b1;
						p_mlast  = phys_q;
						p_count  = count_q - 1'b1;
						p_row    = row - 1'b1;
						p_col    = alen;
						p_llen   = alen + take;
					end
				end
				OP_READ: begin
					p_refuse   = 1'b0;
					p_read_hit = (col < len_q);
				end
				default: begin
					p_refuse = 1'b1;
				end
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= CNT_W'(1);
			init_idx_q <= '0;
			done_q     <= 1'b0;
		end else begin
			if (cmd.init_step) init_idx_q <= init_idx_q + 1'b1;
			if (cmd.decide && !p_refuse) count_q <= p_count;
			done_q <= cmd.finish;
		end
	end

	// payload and pointer registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) req_q <= req;
		if (cmd.look_aux) phys_q <= map_rd_q;
		if (cmd.look_len) begin
			len_q <= len_rd_q;
			aux_q <= map_rd_q;
		end
		if (cmd.decide) begin
			src_q      <= p_src;
			dst_q      <= p_dst;
			n_q        <= p_n;
			cp_dec_q   <= p_dec;
			fill_q     <= p_fill;
			do_ch_q    <= p_ch;
			do_a_q     <= p_a;
			do_b_q     <= p_b;
			do_map_q   <= p_map;
			a_idx_q    <= p_a_idx;
			a_val_q    <= p_a_val;
			b_val_q    <= p_b_val;
			mp_w_q     <= p_mw;
			mp_r_q     <= p_mr;
			mp_end_q   <= p_mend;
			mp_dec_q   <= p_mdec;
			mp_last_q  <= p_mlast;
			read_hit_q <= p_read_hit;
			res_q.status      <= p_refuse;
			res_q.new_row     <= p_row;
			res_q.new_col     <= p_col;
			res_q.line_count  <= p_refuse ? count_q : p_count;
			res_q.line_length <= p_llen;
		end
		// advance the read side one byte ahead of the write side
		if (cmd.cp_prime || cmd.cp_move) src_q <= cp_dec_q ? src_q - 1'b1 : src_q + 1'b1;
		if (cmd.cp_move) begin
			dst_q <= cp_dec_q ? dst_q - 1'b1 : dst_q + 1'b1;
			n_q   <= n_q - 1'b1;
		end
		if (cmd.mp_prime || cmd.mp_move) mp_r_q <= mp_dec_q ? mp_r_q - 1'b1 : mp_r_q + 1'b1;
		if (cmd.mp_move) mp_w_q <= mp_dec_q ? mp_w_q - 1'b1 : mp_w_q + 1'b1;
		if (cmd.finish) res_q.char_out <= read_hit_q ? txt_rd_q : 8'h00;
	end

	// memory port muxes
	always_comb begin
		txt_ra = cmd.decide ? {phys_q, col} : src_q;
		txt_we = cmd.cp_move || cmd.wr_ch;
		txt_wa = cmd.wr_ch ? {phys_q, col} : dst_q;
		txt_wd = cmd.wr_ch ? req_q.ch : (fill_q ? SPACE : txt_rd_q);

		len_we = cmd.init_step || cmd.len_a || cmd.len_b;
		len_wa = cmd.init_step ? init_idx_q : (cmd.len_b ? aux_q : a_idx_q);
		len_wd = cmd.init_step ? '0 : (cmd.len_b ? b_val_q : a_val_q);

		if (cmd.look_row) begin
			map_ra = row;
		end else if (cmd.look_aux) begin
			map_ra = aux_idx;
		end else begin
			map_ra = mp_r_q;
		end
		map_we = cmd.init_step || cmd.mp_move || cmd.mp_last;
		if (cmd.init_step) begin
			map_wa = init_idx_q;
			map_wd = init_idx_q;
		end else if (cmd.mp_last) begin
			map_wa = mp_end_q;
			map_wd = mp_last_q;
		end else begin
			map_wa = mp_w_q;
			map_wd = map_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (txt_we) txt_mem[txt_wa] <= txt_wd;
		txt_rd_q <= txt_mem[txt_ra];
	end

	always_ff @(posedge clk) begin
		if (len_we) len_mem[len_wa] <= len_wd;
		len_rd_q <= len_mem[map_rd_q];
	end

	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_wa] <= map_wd;
		map_rd_q <= map_mem[map_ra];
	end

	always_comb begin
		stat.init_last   = &init_idx_q;
		stat.refuse      = p_refuse;
		stat.is_read     = (req_q.req_type == OP_READ);
		stat.cp_zero     = (n_q == '0);
		stat.cp_one      = (n_q == COL_W'(1));
		stat.do_ch       = do_ch_q;
		stat.do_len_a    = do_a_q;
		stat.do_len_b    = do_b_q;
		stat.do_map      = do_map_q;
		stat.mp_at_end   = (mp_w_q == mp_end_q);
		stat.mp_near_end = ((mp_dec_q ? mp_w_q - 1'b1 : mp_w_q + 1'b1) == mp_end_q);
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

### rtl/lte_checker.sv
// ----------------------------------------------------------------------------
// lte_checker
// Port-level checks of the line text buffer editor.
// ----------------------------------------------------------------------------
`include "line_text_buffer_editor_macros.svh"

module lte_checker import lte_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input req_t req,
	input logic busy,
	input logic done,
	input res_t result
);

	// a transaction result only appears once the block is free again
	`LTE_NEVER(a_done_busy, done && busy, "result strobe while busy")
	`LTE_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted transaction did not raise busy")
	`LTE_ASSERT(a_count_range, done |-> result.line_count != 0 && result.line_count <= 64, "line count out of range")
	`LTE_ASSERT(a_row_in_use, done && !result.status |-> result.new_row < result.line_count, "cursor row beyond line count")
	`LTE_ASSERT(a_char_valid, done && result.char_out != 0 |-> !result.status && result.new_col < result.line_length, "read byte outside line")

endmodule

bind line_text_buffer_editor lte_checker u_lte_checker (.*);

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the line text buffer editor: a directed table of
// requests, then random edit sessions, all checked against a behavioral copy
// of the line store, with random start gaps.
// ----------------------------------------------------------------------------
module testbench;
	import lte_pkg::*;

	localparam int LIMIT_CYCLES = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	res_t result;

	line_text_buffer_editor u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .result(result)
	);

	always #5 clk = ~clk;

	// behavioral copy of the store
	logic [7:0] text_mem [LINES][COLS];
	int unsigned len_mem [LINES];
	int unsigned line_total;

	res_t pending_results [$];
	int errors = 0;
	int cycles = 0;

	function automatic res_t edit_line(req_t r);
		res_t o;
		int unsigned row, col, len, sc, plen, take;
		logic [7:0] tmp [COLS];
		row = r.cursor_row;
		col = r.cursor_col;
		o = '0;
		o.status = 1'b1;
		o.new_row = r.cursor_row;
		o.new_col = r.cursor_col;
		if (row < line_total) begin
			len = len_mem[row];
			case (r.req_type)
				OP_INSERT: if (col < COLS - 1 && len < COLS - 1) begin
					for (int k = len; k < col; k++) text_mem[row][k] = SPACE;
					if (col > len) len = col;
					for (int k = len; k > col; k--) text_mem[row][k] = text_mem[row][k-1];
					text_mem[row][col] = r.ch;
					len_mem[row] = len + 1;
					o.new_col = COL_W'(col + 1);
					o.status = 1'b0;
				end
				OP_DELETE: if (col > 0) begin
					if (col <= len) begin
						for (int k = col - 1; k < len - 1; k++)
							text_mem[row][k] = text_mem[row][k+1];
						len_mem[row] = len - 1;
					end
					o.new_col = COL_W'(col - 1);
					o.status = 1'b0;
				end
				OP_SPLIT: if (line_total < LINES) begin
					sc = col < len ? col : len;
					for (int k = line_total; k >= row + 2; k--) begin
						text_mem[k] = text_mem[k-1];
						len_mem[k] = len_mem[k-1];
					end
					tmp = text_mem[row];
					for (int k = 0; k < len - sc; k++) text_mem[row+1][k] = tmp[sc+k];
					len_mem[row+1] = len - sc;
					len_mem[row] = sc;
					line_total++;
					o.new_row = ROW_W'(row + 1);
					o.new_col = '0;
					o.status = 1'b0;
				end
				OP_MERGE: if (row > 0) begin
					plen = len_mem[row-1];
					take = len < (COLS - 1 - plen) ? len : (COLS - 1 - plen);
					for (int k = 0; k < take; k++) text_mem[row-1][plen+k] = text_mem[row][k];
					len_mem[row-1] = plen + take;
					for (int k = row; k < line_total - 1; k++) begin
						text_mem[k] = text_mem[k+1];
						len_mem[k] = len_mem[k+1];
					end
					line_total--;
					o.new_row = ROW_W'(row - 1);
					o.new_col = COL_W'(plen);
					o.status = 1'b0;
				end
				OP_READ: begin
					if (col < len) o.char_out = text_mem[row][col];
					o.status = 1'b0;
				end
				default: ;
			endcase
			o.line_length = COL_W'(len_mem[o.new_row]);
		end
		o.line_count = CNT_W'(line_total);
		return o;
	endfunction

	// result checker
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no pending request");
				errors++;
			end else begin
				res_t e;
				e = pending_results.pop_front();
				if (result.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, result.status);
					errors++;
				end
				if (result.new_row !== e.new_row) begin
					$error("new_row exp %0d got %0d", e.new_row, result.new_row);
					errors++;
				end
				if (result.new_col !== e.new_col) begin
					$error("new_col exp %0d got %0d", e.new_col, result.new_col);
					errors++;
				end
				if (result.line_count !== e.line_count) begin
					$error("line_count exp %0d got %0d", e.line_count, result.line_count);
					errors++;
				end
				if (result.line_length !== e.line_length) begin
					$error("line_length exp %0d got %0d", e.line_length, result.line_length);
					errors++;
				end
				if (result.char_out !== e.char_out) begin
					$error("char_out exp %0d got %0d", e.char_out, result.char_out);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > LIMIT_CYCLES) begin
			$display("** line_text_buffer_editor: FAILED **");
			$finish;
		end
	end

	// send one transaction; fixed_chk asks for a typed-in expectation to be compared too
	task automatic send(req_t r, bit fixed_chk, res_t fixed_res);
		res_t e;
		int gap;
		gap = $urandom_range(0, 12);
		if ($urandom_range(0, 3) == 0) gap = 0;
		repeat (gap) @(posedge clk);
		while (busy) @(posedge clk);
		e = edit_line(r);
		if (fixed_chk && e !== fixed_res) begin
			$error("table row exp %h, predictor %h", fixed_res, e);
			errors++;
		end
		pending_results.push_back(e);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		start <= 1'b0;
		// wait for busy to show the accepted transaction
		@(posedge clk);
	endtask

	function automatic req_t mk(logic [2:0] op, logic [7:0] c, int unsigned row, int unsigned col);
		req_t r;
		r.req_type = op;
		r.ch = c;
		r.cursor_row = ROW_W'(row);
		r.cursor_col = COL_W'(col);
		return r;
	endfunction

	function automatic res_t rs(logic st, int unsigned row, int unsigned col, int unsigned cnt,
			int unsigned len, logic [7:0] c);
		res_t o;
		o.status = st; o.new_row = ROW_W'(row); o.new_col = COL_W'(col);
		o.line_count = CNT_W'(cnt); o.line_length = COL_W'(len); o.char_out = c;
		return o;
	endfunction

	typedef struct {
		req_t r;
		bit chk;
		res_t o;
	} dir_row_t;

	dir_row_t dir_table [$];

	initial begin
		req_t r;
		int pick;
		for (int i = 0; i < LINES; i++) begin
			len_mem[i] = 0;
			for (int k = 0; k < COLS; k++) text_mem[i][k] = 8'h00;
		end
		line_total = 1;

		dir_table = '{
			'{mk(OP_READ, 8'h00, 0, 0), 1, rs(0, 0, 0, 1, 0, 8'h00)},
			'{mk(OP_READ, 8'hFF, 63, 127), 1, rs(1, 63, 127, 1, 0, 8'h00)},
			'{mk(OP_DELETE, 8'h00, 0, 0), 1, rs(1, 0, 0, 1, 0, 8'h00)},
			'{mk(OP_MERGE, 8'h00, 0, 5), 1, rs(1, 0, 5, 1, 0, 8'h00)},
			'{mk(3'd5, 8'h00, 0, 0), 1, rs(1, 0, 0, 1, 0, 8'h00)},
			'{mk(3'd7, 8'hAA, 0, 3), 1, rs(1, 0, 3, 1, 0, 8'h00)},
			'{mk(OP_INSERT, 8'h41, 0, 127), 1, rs(1, 0, 127, 1, 0, 8'h00)},
			'{mk(OP_INSERT, 8'hFF, 0, 126), 1, rs(0, 0, 127, 1, 127, 8'h00)},
			'{mk(OP_INSERT, 8'h01, 0, 0), 1, rs(1, 0, 0, 1, 127, 8'h00)},
			'{mk(OP_READ, 8'h00, 0, 126), 1, rs(0, 0, 126, 1, 127, 8'hFF)},
			'{mk(OP_READ, 8'h00, 0, 5), 1, rs(0, 0, 5, 1, 127, SPACE)},
			'{mk(OP_SPLIT, 8'h00, 0, 120), 0, '0},
			'{mk(OP_MERGE, 8'h00, 1, 0), 0, '0},
			'{mk(OP_SPLIT, 8'h00, 0, 0), 0, '0},
			'{mk(OP_INSERT, 8'h55, 1, 3), 0, '0},
			'{mk(OP_DELETE, 8'h00, 1, 100), 0, '0},
			'{mk(OP_DELETE, 8'h00, 1, 4), 0, '0},
			'{mk(OP_SPLIT, 8'h00, 1, 127), 0, '0},
			'{mk(OP_MERGE, 8'h00, 1, 0), 0, '0},
			'{mk(OP_MERGE, 8'h00, 1, 0), 0, '0},
			'{mk(OP_READ, 8'h00, 2, 0), 0, '0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i]) send(dir_table[i].r, dir_table[i].chk, dir_table[i].o);

		for (int n = 0; n < 2000; n++) begin
			// hold off once until the block has drained
			if (n == 1000) while (pending_results.size() != 0) @(posedge clk);
			pick = $urandom_range(0, 99);
			r.ch = 8'($urandom_range(1, 255));
			r.cursor_row = line_total > 1 ? ROW_W'($urandom_range(0, line_total - 1)) : '0;
			r.cursor_col = COL_W'($urandom_range(0, len_mem[r.cursor_row] + 3));
			if (pick < 45) r.req_type = OP_INSERT;
			else if (pick < 60) r.req_type = OP_DELETE;
			else if (pick < 72) r.req_type = OP_SPLIT;
			else if (pick < 82) r.req_type = OP_MERGE;
			else if (pick < 94) r.req_type = OP_READ;
			else begin
				// noise: any op code, any row and column
				r.req_type = 3'($urandom_range(0, 7));
				r.cursor_row = ROW_W'($urandom_range(0, 63));
				r.cursor_col = COL_W'($urandom_range(0, 127));
			end
			if ($urandom_range(0, 19) == 0) r.cursor_col = COL_W'($urandom_range(0, 127));
			// drain the table now and then so the line count falls again
			if ((n % 400) > 300 && r.req_type == OP_INSERT) r.req_type = OP_MERGE;
			send(r, 0, '0);
		end

		while (pending_results.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("** line_text_buffer_editor: PASSED **");
		else
			$display("** line_text_buffer_editor: FAILED **");
		$finish;
	end
endmodule
